[rtl/fpr_pkg.sv]
package fpr_pkg;

	localparam int FRAMES    = 16;
	localparam int PAGE_BITS = 8;
	localparam int SLOT_W    = $clog2(FRAMES);
	localparam int CNT_W     = $clog2(FRAMES + 1);
	localparam int LIMIT_W   = 5;
	localparam int TOTAL_W   = 16;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4);
	localparam logic [TOTAL_W-1:0] TOTAL_MAX   = {TOTAL_W{1'b1}};

	typedef logic [PAGE_BITS-1:0] page_t;
	typedef logic [SLOT_W-1:0]    slot_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic exec;
	} fpr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_full;
	} fpr_sts_t;

endpackage

[rtl/fpr_ctrl.sv]
module fpr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              out_stall,
	input  fpr_pkg::fpr_sts_t sts,
	output fpr_pkg::fpr_cmd_t cmd
);
	import fpr_pkg::*;

	localparam logic [0:0] ST_IDLE = 1'b0;
	localparam logic [0:0] ST_EXEC = 1'b1;

	logic [0:0] state_q;
	logic [0:0] state_d;
	logic       out_free;

	// output register can take a new result this cycle
	assign out_free = !sts.out_full || !out_stall;

	always_comb begin
		state_d     = state_q;
		in_stall    = 1'b0;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				in_stall = 1'b1;
				if (out_free) begin
					cmd.exec = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/fpr_dp.sv]
module fpr_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  fpr_pkg::fpr_cmd_t               cmd,
	output fpr_pkg::fpr_sts_t               sts,
	input  logic                            cfg_we,
	input  logic [fpr_pkg::LIMIT_W-1:0]     cfg_limit,
	input  logic [7:0]                      page_number,
	input  logic                            out_stall,
	output logic                            out_valid,
	output logic                            hit,
	output logic                            evicted_valid,
	output logic [7:0]                      evicted_page,
	output logic [fpr_pkg::TOTAL_W-1:0]     hit_total,
	output logic [fpr_pkg::TOTAL_W-1:0]     fault_total
);
	import fpr_pkg::*;

	page_t               pages_q [FRAMES];
	page_t               page_q;
	cnt_t                count_q;
	slot_t               oldest_q;
	logic [TOTAL_W-1:0]  hits_q;
	logic [TOTAL_W-1:0]  faults_q;
	logic [LIMIT_W-1:0]  limit_cfg_q;
	logic                out_valid_q;

	logic [LIMIT_W-1:0]  limit;
	logic [FRAMES-1:0]   match_vec;
	logic                is_hit;
	logic                evict;
	slot_t               oldest_d;
	cnt_t                count_base;
	logic [SLOT_W:0]     wr_sum;
	slot_t               wr_slot;

	// clamp the frame limit to 1..FRAMES
	always_comb begin
		priority if (limit_cfg_q == '0) begin
			limit = LIMIT_W'(1);
		end else if (limit_cfg_q > LIMIT_W'(FRAMES)) begin
			limit = LIMIT_W'(FRAMES);
		end else begin
			limit = limit_cfg_q;
		end
	end

	// parallel compare against occupied slots
	always_comb begin
		for (int i = 0; i < FRAMES; i++) begin
			logic [SLOT_W:0] off;
			if (SLOT_W'(i) >= oldest_q) begin
				off = (SLOT_W+1)'(SLOT_W'(i) - oldest_q);
			end else begin
				off = (SLOT_W+1)'(i) + (SLOT_W+1)'(FRAMES) - {1'b0, oldest_q};
			end
			match_vec[i] = (CNT_W'(off) < count_q) && (pages_q[i] == page_q);
		end
	end

	assign is_hit = |match_vec;
	assign evict  = (CNT_W'(count_q) >= CNT_W'(limit)) && (count_q != '0);

	always_comb begin
		if (evict) begin
			oldest_d   = (oldest_q == SLOT_W'(FRAMES - 1)) ? '0 : oldest_q + SLOT_W'(1);
			count_base = count_q - CNT_W'(1);
		end else begin
			oldest_d   = oldest_q;
			count_base = count_q;
		end
		wr_sum = {1'b0, oldest_d} + (SLOT_W+1)'(count_base);
		if (wr_sum >= (SLOT_W+1)'(FRAMES)) begin
			wr_slot = SLOT_W'(wr_sum - (SLOT_W+1)'(FRAMES));
		end else begin
			wr_slot = SLOT_W'(wr_sum);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			page_q <= PAGE_BITS'(page_number);
		end
		if (cmd.exec && !is_hit) begin
			pages_q[wr_slot] <= page_q;
		end
		if (cmd.exec) begin
			hit           <= is_hit;
			evicted_valid <= !is_hit && evict;
			evicted_page  <= (!is_hit && evict) ? 8'(pages_q[oldest_q]) : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			oldest_q    <= '0;
			hits_q      <= '0;
			faults_q    <= '0;
			limit_cfg_q <= LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_cfg_q <= cfg_limit;
			end
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
				if (is_hit) begin
					if (hits_q != TOTAL_MAX) begin
						hits_q <= hits_q + TOTAL_W'(1);
					end
				end else begin
					if (faults_q != TOTAL_MAX) begin
						faults_q <= faults_q + TOTAL_W'(1);
					end
					oldest_q <= oldest_d;
					count_q  <= count_base + CNT_W'(1);
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// totals follow the counters, which only move together with a new result
	assign hit_total    = hits_q;
	assign fault_total  = faults_q;
	assign out_valid    = out_valid_q;
	assign sts.out_full = out_valid_q;

endmodule

[rtl/fifo_page_replacement_unit.sv]
// fifo page replacement unit: each input transaction carries one page reference,
// which is checked against the resident frames; a hit is counted, a miss is
// counted as a fault and the page is inserted, evicting the oldest resident
// page first when the frame limit (frames_in_use, 1..16, reset 4, 0 acts as 1,
// larger values act as 16) is reached. one output transaction per reference
// gives hit, the evicted page if any, and saturating hit and fault totals.
// a reference is first registered, then the parallel compare across the 16 frame
// registers and the frame store update run once the output register is free;
// in_stall is held until then, so a new reference is taken only after the last
// result is registered, and is captured while that result waits to be taken.
// the frame store starts empty with no clearing pass; lowering the limit while
// full leaves the set at its size, one eviction per fault. cfg_ready is always high.
module fifo_page_replacement_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration write channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [fpr_pkg::LIMIT_W-1:0] frames_in_use,
	// reference input channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  page_number,
	// result output channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        hit,
	output logic                        evicted_valid,
	output logic [7:0]                  evicted_page,
	output logic [fpr_pkg::TOTAL_W-1:0] hit_total,
	output logic [fpr_pkg::TOTAL_W-1:0] fault_total
);
	import fpr_pkg::*;

	fpr_cmd_t cmd;
	fpr_sts_t sts;

	// the limit register is a plain write, never back-pressured
	assign cfg_ready = 1'b1;

	// sequencer: capture a reference, then run the lookup and update
	fpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// frame store, fifo pointers, counters and result register
	fpr_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_limit     (frames_in_use),
		.page_number   (page_number),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.hit           (hit),
		.evicted_valid (evicted_valid),
		.evicted_page  (evicted_page),
		.hit_total     (hit_total),
		.fault_total   (fault_total)
	);

endmodule
